@@ hdl/cbra_pkg.sv @@
// ----------------------------------------------------------------------------
// cbra_pkg
// shared constants and helpers of the cbor reply arg extractor
// ----------------------------------------------------------------------------
package cbra_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int LEN_BITS_DEF  = 32;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_PREFIX  = 3'd1;
    localparam logic [2:0] PH_HEAD    = 3'd2;
    localparam logic [2:0] PH_EXT     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_IDLE    = 3'd5;

    localparam logic [2:0] ROLE_ARR   = 3'd0;
    localparam logic [2:0] ROLE_MAP   = 3'd2;
    localparam logic [2:0] ROLE_TOP   = 3'd4;
    localparam logic [2:0] ROLE_REPLY = 3'd6;

    localparam logic [1:0] KEY_NONE   = 2'd0;
    localparam logic [1:0] KEY_STATUS = 2'd1;
    localparam logic [1:0] KEY_REPLY  = 2'd2;
    localparam logic [1:0] KEY_ARG    = 2'd3;

    localparam logic [1:0] USE_SKIP  = 2'd0;
    localparam logic [1:0] USE_MATCH = 2'd1;
    localparam logic [1:0] USE_ARG   = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_MALFORMED   = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd2;
    localparam logic [2:0] ERR_NOT_REPLIED = 3'd3;
    localparam logic [2:0] ERR_NO_ARG      = 3'd4;
    localparam logic [2:0] ERR_DEEP        = 3'd5;

    localparam logic [7:0] TAG_PREFIX = 8'hD9;
    localparam logic [7:0] TAG_SELF   = 8'hF7;
    localparam logic [4:0] AI_DIRECT  = 5'd23;
    localparam logic [4:0] AI_INDEF   = 5'd31;

    localparam logic [2:0] MT_BYTES = 3'd2;
    localparam logic [2:0] MT_TEXT  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;
    localparam logic [2:0] MT_OTHER = 3'd7;

    // words: 0 status, 1 reply, 2 arg, 3 replied
    function automatic logic [3:0] word_len(input logic [1:0] w);
        logic [3:0] l;
        case (w)
            2'd0:    l = 4'd6;
            2'd1:    l = 4'd5;
            2'd2:    l = 4'd3;
            default: l = 4'd7;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] p);
        logic [63:0] s;
        logic [5:0]  idx;
        case (w)
            2'd0:    s = {"status", 16'h0};
            2'd1:    s = {"reply", 24'h0};
            2'd2:    s = {"arg", 40'h0};
            default: s = {"replied", 8'h0};
        endcase
        idx = {3'd7 - p, 3'b000};
        return s[idx +: 8];
    endfunction

endpackage

@@ hdl/cbra_body_if.sv @@
// ----------------------------------------------------------------------------
// cbra_body_if
// body byte channel
// ----------------------------------------------------------------------------
interface cbra_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       body_end;

    modport source (output valid, body_byte, body_end, input ready);
    modport sink (input valid, body_byte, body_end, output ready);
endinterface

@@ hdl/cbra_res_if.sv @@
// ----------------------------------------------------------------------------
// cbra_res_if
// result channel
// ----------------------------------------------------------------------------
interface cbra_res_if;
    logic       valid;
    logic       ready;
    logic       arg_begin;
    logic       arg_valid;
    logic [7:0] arg_data;
    logic       done_res;
    logic       success;
    logic [2:0] error_kind;

    modport source (output valid, arg_begin, arg_valid, arg_data, done_res, success,
                    error_kind, input ready);
    modport sink (input valid, arg_begin, arg_valid, arg_data, done_res, success,
                  error_kind, output ready);
endinterface

@@ hdl/cbor_reply_arg_extractor.sv @@
// output: each result item is registered; a byte that closes nested levels first
//   passes through S_POP once per level read back from the level memory
// throughput: 1 byte per cycle while the result output is not stalled, except
//   bytes that close nested levels, which hold the input while S_POP reads each level back
// reset: synchronous, active low; the level memory needs no clearing pass
// ----------------------------------------------------------------------------
// cbor_reply_arg_extractor
// streaming cbor reply parser, emits the bytes of reply/arg and a verdict
// ----------------------------------------------------------------------------
module cbor_reply_arg_extractor #(
    parameter int MAX_DEPTH = cbra_pkg::MAX_DEPTH_DEF,
    parameter int LEN_BITS  = cbra_pkg::LEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbra_body_if.sink   i_body,
    cbra_res_if.source  o_res
);

    localparam int NW    = $clog2(MAX_DEPTH + 1);
    localparam int AW    = $clog2(MAX_DEPTH);
    localparam int REM_W = LEN_BITS + 1;
    localparam int ENT_W = REM_W + 3;
    localparam logic S_RUN = 1'b0;
    localparam logic S_POP = 1'b1;

    logic [ENT_W-1:0] mem [MAX_DEPTH];
    logic [ENT_W-1:0] r_rdata;

    logic             r_state, n_state;
    logic [NW-1:0]    r_nest, n_nest;
    logic [2:0]       r_phase, n_phase;
    logic [1:0]       r_prefix, n_prefix;
    logic [2:0]       r_hmajor, n_hmajor;
    logic [3:0]       r_hbytes, n_hbytes;
    logic [63:0]      r_hval, n_hval;
    logic [LEN_BITS-1:0] r_pleft, n_pleft;
    logic [3:0]       r_mpos, n_mpos;
    logic [3:0]       r_malive, n_malive;
    logic [1:0]       r_key, n_key;
    logic             r_replied, n_replied;
    logic             r_argf, n_argf;
    logic             r_fin, n_fin;
    logic [2:0]       r_err, n_err;
    logic [1:0]       r_use, n_use;
    logic             r_tag, n_tag;
    logic [REM_W-1:0] r_top_rem, n_top_rem;
    logic [2:0]       r_top_role, n_top_role;
    logic             r_p_begin, n_p_begin;
    logic             r_p_valid, n_p_valid;
    logic [7:0]       r_p_data, n_p_data;
    logic             r_p_end, n_p_end;
    logic             r_ov, n_ov;
    logic             r_obeg, n_obeg;
    logic             r_oval, n_oval;
    logic [7:0]       r_odat, n_odat;
    logic             r_odone, n_odone;
    logic             r_ook, n_ook;
    logic [2:0]       r_oerr, n_oerr;

    logic             accept;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign i_body.ready = (r_state == S_RUN) && (!r_ov || o_res.ready);
    assign accept       = i_body.valid && i_body.ready;
    assign wr_addr      = AW'(r_nest - 1'b1);

    assign o_res.valid      = r_ov;
    assign o_res.arg_begin  = r_obeg;
    assign o_res.arg_valid  = r_oval;
    assign o_res.arg_data   = r_odat;
    assign o_res.done_res   = r_odone;
    assign o_res.success    = r_ook;
    assign o_res.error_kind = r_oerr;

    always_comb begin
        logic [7:0]       b;
        logic             hb_en, hd_en, hd_indef, ss_en, fs_en, oc_en, oc_map, oc_indef;
        logic [2:0]       hd_major, oc_role, fail_code, role2, vd_err;
        logic [63:0]      hd_v, hv;
        logic [4:0]       ai;
        logic [1:0]       ss_use, kval;
        logic [3:0]       ss_cand, hleft;
        logic             idone, pop_req, setkey, big, is_key, fin_now, end_now;
        logic [REM_W-1:0] cnt, rem2;
        logic             beg_c, val_c;
        logic [7:0]       dat_c;
        logic [NW-1:0]    nn;

        n_state = r_state; n_nest = r_nest; n_phase = r_phase; n_prefix = r_prefix;
        n_hmajor = r_hmajor; n_hbytes = r_hbytes; n_hval = r_hval; n_pleft = r_pleft;
        n_mpos = r_mpos; n_malive = r_malive; n_key = r_key; n_replied = r_replied;
        n_argf = r_argf; n_fin = r_fin; n_err = r_err; n_use = r_use; n_tag = r_tag;
        n_top_rem = r_top_rem; n_top_role = r_top_role;
        n_p_begin = r_p_begin; n_p_valid = r_p_valid; n_p_data = r_p_data;
        n_p_end = r_p_end;
        n_ov = r_ov; n_obeg = r_obeg; n_oval = r_oval; n_odat = r_odat;
        n_odone = r_odone; n_ook = r_ook; n_oerr = r_oerr;

        b = i_body.body_byte;
        hb_en = 1'b0; hd_en = 1'b0; hd_indef = 1'b0; hd_major = 3'd0; hd_v = '0;
        ss_en = 1'b0; ss_use = cbra_pkg::USE_SKIP; ss_cand = 4'd0;
        fs_en = 1'b0; oc_en = 1'b0; oc_map = 1'b0; oc_indef = 1'b0; oc_role = 3'd0;
        fail_code = cbra_pkg::ERR_NONE; idone = 1'b0; pop_req = 1'b0;
        setkey = 1'b0; kval = cbra_pkg::KEY_NONE; big = 1'b0; is_key = 1'b0;
        cnt = '0; rem2 = '0; role2 = 3'd0; hv = '0; ai = 5'd0; hleft = 4'd0;
        beg_c = 1'b0; val_c = 1'b0; dat_c = 8'd0; vd_err = cbra_pkg::ERR_NONE;
        mem_we = 1'b0; rd_addr = '0; nn = '0; fin_now = 1'b0; end_now = 1'b0;

        if (r_state == S_POP) begin
            n_top_rem  = r_rdata[REM_W-1:0];
            n_top_role = r_rdata[ENT_W-1 -: 3];
            idone      = 1'b1;
        end else if (accept) begin
            case (r_phase)
                cbra_pkg::PH_START: begin
                    if (b == cbra_pkg::TAG_PREFIX) begin
                        n_phase  = cbra_pkg::PH_PREFIX;
                        n_prefix = 2'd1;
                    end else begin
                        n_phase = cbra_pkg::PH_HEAD;
                        hb_en   = 1'b1;
                    end
                end
                cbra_pkg::PH_PREFIX: begin
                    if (r_prefix == 2'd1 && b == cbra_pkg::TAG_PREFIX) begin
                        n_prefix = 2'd2;
                    end else if (r_prefix == 2'd2 && b == cbra_pkg::TAG_SELF) begin
                        n_prefix = 2'd3;
                        n_phase  = cbra_pkg::PH_HEAD;
                    end else begin
                        fail_code = cbra_pkg::ERR_MALFORMED;
                    end
                end
                cbra_pkg::PH_HEAD: hb_en = 1'b1;
                cbra_pkg::PH_EXT: begin
                    hv     = {r_hval[55:0], b};
                    n_hval = hv;
                    hleft  = (r_hbytes != 4'd0) ? r_hbytes - 4'd1 : r_hbytes;
                    n_hbytes = hleft;
                    if (hleft == 4'd0) begin
                        n_phase  = cbra_pkg::PH_HEAD;
                        hd_en    = 1'b1;
                        hd_major = r_hmajor;
                        hd_v     = hv;
                    end
                end
                cbra_pkg::PH_PAYLOAD: begin
                    if (r_use == cbra_pkg::USE_ARG) begin
                        val_c = 1'b1;
                        dat_c = b;
                    end else if (r_use == cbra_pkg::USE_MATCH) begin
                        for (int i = 0; i < 4; i++) begin
                            if (r_malive[i] && (r_mpos >= cbra_pkg::word_len(2'(i)) ||
                                cbra_pkg::word_char(2'(i), r_mpos[2:0]) != b)) begin
                                n_malive[i] = 1'b0;
                            end
                        end
                        if (r_mpos < 4'd15) n_mpos = r_mpos + 4'd1;
                    end
                    n_pleft = (r_pleft != '0) ? r_pleft - 1'b1 : r_pleft;
                    if (n_pleft == '0) fs_en = 1'b1;
                end
                default: ;
            endcase

            if (hb_en) begin
                ai = b[4:0];
                if (ai <= cbra_pkg::AI_DIRECT) begin
                    hd_en    = 1'b1;
                    hd_major = b[7:5];
                    hd_v     = {59'd0, ai};
                end else if (ai <= 5'd27) begin
                    n_hmajor = b[7:5];
                    n_hval   = '0;
                    n_hbytes = 4'd1 << ai[1:0];
                    n_phase  = cbra_pkg::PH_EXT;
                end else if (ai != cbra_pkg::AI_INDEF) begin
                    fail_code = cbra_pkg::ERR_MALFORMED;
                end else if (b[7:5] == cbra_pkg::MT_OTHER) begin
                    if (r_nest == '0 || r_tag || !r_top_role[0] ||
                        ((r_top_role[2] || r_top_role[1]) && r_top_rem[0])) begin
                        fail_code = cbra_pkg::ERR_MALFORMED;
                    end else begin
                        n_nest = r_nest - 1'b1;
                        if (n_nest == '0) idone = 1'b1;
                        else pop_req = 1'b1;
                    end
                end else if (b[7:5] == cbra_pkg::MT_ARRAY || b[7:5] == cbra_pkg::MT_MAP) begin
                    hd_en    = 1'b1;
                    hd_major = b[7:5];
                    hd_indef = 1'b1;
                end else begin
                    fail_code = cbra_pkg::ERR_MALFORMED;
                end
            end
        end

        // header complete
        if (hd_en) begin
            big    = |(hd_v >> LEN_BITS);
            role2  = r_top_role & 3'd6;
            is_key = (r_top_role[2] || r_top_role[1]) && !r_top_rem[0];
            if (r_nest == '0) begin
                if (hd_major != cbra_pkg::MT_MAP) fail_code = cbra_pkg::ERR_MALFORMED;
                else begin
                    oc_en = 1'b1; oc_map = 1'b1; oc_role = cbra_pkg::ROLE_TOP;
                end
            end else if ((role2 == cbra_pkg::ROLE_TOP || role2 == cbra_pkg::ROLE_REPLY)
                         && is_key) begin
                if (hd_major != cbra_pkg::MT_TEXT) fail_code = cbra_pkg::ERR_MALFORMED;
                else begin
                    ss_en = 1'b1; ss_use = cbra_pkg::USE_MATCH;
                    ss_cand = (role2 == cbra_pkg::ROLE_TOP) ? 4'd3 : 4'd4;
                end
            end else if (role2 == cbra_pkg::ROLE_TOP && r_key == cbra_pkg::KEY_STATUS) begin
                if (hd_major != cbra_pkg::MT_TEXT) fail_code = cbra_pkg::ERR_MALFORMED;
                else begin
                    ss_en = 1'b1; ss_use = cbra_pkg::USE_MATCH; ss_cand = 4'd8;
                end
            end else if (role2 == cbra_pkg::ROLE_TOP && r_key == cbra_pkg::KEY_REPLY) begin
                if (hd_major != cbra_pkg::MT_MAP) fail_code = cbra_pkg::ERR_MALFORMED;
                else begin
                    oc_en = 1'b1; oc_map = 1'b1; oc_role = cbra_pkg::ROLE_REPLY;
                end
            end else if (role2 == cbra_pkg::ROLE_REPLY && r_key == cbra_pkg::KEY_ARG) begin
                if (hd_major != cbra_pkg::MT_BYTES || big) begin
                    fail_code = cbra_pkg::ERR_MALFORMED;
                end else begin
                    n_argf = 1'b1;
                    beg_c  = 1'b1;
                    ss_en  = 1'b1; ss_use = cbra_pkg::USE_ARG;
                end
            end else begin
                case (hd_major)
                    cbra_pkg::MT_BYTES, cbra_pkg::MT_TEXT: ss_en = 1'b1;
                    cbra_pkg::MT_ARRAY: begin
                        oc_en = 1'b1; oc_role = cbra_pkg::ROLE_ARR;
                    end
                    cbra_pkg::MT_MAP: begin
                        oc_en = 1'b1; oc_map = 1'b1; oc_role = cbra_pkg::ROLE_MAP;
                    end
                    cbra_pkg::MT_TAG: n_tag = 1'b1;
                    default: idone = 1'b1;
                endcase
            end
            oc_indef = hd_indef;
        end

        // open container
        if (oc_en) begin
            if (!oc_indef && (big || (oc_map && hd_v[63]))) begin
                fail_code = cbra_pkg::ERR_MALFORMED;
            end else begin
                if (!oc_indef) begin
                    cnt = oc_map ? {hd_v[LEN_BITS-1:0], 1'b0} : {1'b0, hd_v[LEN_BITS-1:0]};
                end
                if (!oc_indef && cnt == '0) begin
                    idone = 1'b1;
                end else if (r_nest >= NW'(MAX_DEPTH)) begin
                    fail_code = cbra_pkg::ERR_DEEP;
                end else begin
                    mem_we     = (r_nest != '0);
                    n_top_role = oc_role | {2'b00, oc_indef};
                    n_top_rem  = cnt;
                    n_nest     = r_nest + 1'b1;
                    n_tag      = 1'b0;
                end
            end
        end

        // start string
        if (ss_en) begin
            if (|(hd_v >> LEN_BITS)) begin
                fail_code = cbra_pkg::ERR_MALFORMED;
            end else begin
                n_pleft  = hd_v[LEN_BITS-1:0];
                n_use    = ss_use;
                n_mpos   = 4'd0;
                n_malive = 4'd0;
                for (int i = 0; i < 4; i++) begin
                    if (ss_cand[i] && hd_v == 64'(cbra_pkg::word_len(2'(i))))
                        n_malive[i] = 1'b1;
                end
                if (hd_v == '0) fs_en = 1'b1;
                else n_phase = cbra_pkg::PH_PAYLOAD;
            end
        end

        // finish string
        if (fs_en) begin
            n_phase = cbra_pkg::PH_HEAD;
            if (n_use == cbra_pkg::USE_MATCH && r_nest != '0) begin
                is_key = (r_top_role[2] || r_top_role[1]) && !r_top_rem[0];
                if (is_key) begin
                    setkey = 1'b1;
                    if (r_top_role >= cbra_pkg::ROLE_REPLY)
                        kval = n_malive[2] ? cbra_pkg::KEY_ARG : cbra_pkg::KEY_NONE;
                    else if (n_malive[0]) kval = cbra_pkg::KEY_STATUS;
                    else if (n_malive[1]) kval = cbra_pkg::KEY_REPLY;
                end else begin
                    n_replied = n_malive[3];
                end
            end
            idone = 1'b1;
        end

        // one item done in the innermost level
        if (idone) begin
            n_tag = 1'b0;
            if (n_nest == '0) begin
                n_fin   = 1'b1;
                n_phase = cbra_pkg::PH_IDLE;
            end else begin
                if (n_top_role[2]) n_key = cbra_pkg::KEY_NONE;
                if (n_top_role[0]) begin
                    n_top_rem[0] = ~n_top_rem[0];
                end else begin
                    rem2 = (n_top_rem != '0) ? n_top_rem - 1'b1 : n_top_rem;
                    n_top_rem = rem2;
                    if (rem2 == '0) begin
                        nn = n_nest - 1'b1;
                        n_nest = nn;
                        if (nn == '0) begin
                            n_fin   = 1'b1;
                            n_phase = cbra_pkg::PH_IDLE;
                        end else begin
                            pop_req = 1'b1;
                        end
                    end
                end
            end
        end

        if (setkey) n_key = kval;

        if (fail_code != cbra_pkg::ERR_NONE) begin
            if (n_err == cbra_pkg::ERR_NONE) n_err = fail_code;
            n_phase = cbra_pkg::PH_IDLE;
        end

        if (pop_req) begin
            n_state = S_POP;
            rd_addr = AW'(n_nest - 1'b1);
        end else begin
            n_state = S_RUN;
        end

        if (accept) begin
            n_p_begin = beg_c;
            n_p_valid = val_c;
            n_p_data  = dat_c;
            n_p_end   = i_body.body_end;
        end

        if (r_ov && o_res.ready) n_ov = 1'b0;

        fin_now = (r_state == S_POP || accept) && !pop_req;
        end_now = (r_state == S_POP) ? r_p_end : i_body.body_end;
        if (fin_now) begin
            n_ov   = 1'b1;
            n_obeg = (r_state == S_POP) ? r_p_begin : beg_c;
            n_oval = (r_state == S_POP) ? r_p_valid : val_c;
            n_odat = (r_state == S_POP) ? r_p_data : dat_c;
            n_odone = end_now;
            n_ook   = 1'b0;
            n_oerr  = cbra_pkg::ERR_NONE;
            if (end_now) begin
                if (n_err != cbra_pkg::ERR_NONE) vd_err = n_err;
                else if (!n_fin) vd_err = cbra_pkg::ERR_TRUNCATED;
                else if (!n_replied) vd_err = cbra_pkg::ERR_NOT_REPLIED;
                else if (!n_argf) vd_err = cbra_pkg::ERR_NO_ARG;
                n_ook  = (vd_err == cbra_pkg::ERR_NONE);
                n_oerr = vd_err;
                n_nest = '0; n_phase = cbra_pkg::PH_START; n_prefix = 2'd0;
                n_hmajor = 3'd0; n_hbytes = 4'd0; n_hval = '0; n_pleft = '0;
                n_mpos = 4'd0; n_malive = 4'd0; n_key = cbra_pkg::KEY_NONE;
                n_replied = 1'b0; n_argf = 1'b0; n_fin = 1'b0;
                n_err = cbra_pkg::ERR_NONE; n_use = cbra_pkg::USE_SKIP; n_tag = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {r_top_role, r_top_rem};
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN; r_nest <= '0; r_phase <= cbra_pkg::PH_START;
            r_prefix <= 2'd0; r_hmajor <= 3'd0; r_hbytes <= 4'd0; r_hval <= '0;
            r_pleft <= '0; r_mpos <= 4'd0; r_malive <= 4'd0;
            r_key <= cbra_pkg::KEY_NONE; r_replied <= 1'b0; r_argf <= 1'b0;
            r_fin <= 1'b0; r_err <= cbra_pkg::ERR_NONE; r_use <= cbra_pkg::USE_SKIP;
            r_tag <= 1'b0; r_top_rem <= '0; r_top_role <= cbra_pkg::ROLE_ARR;
            r_p_begin <= 1'b0; r_p_valid <= 1'b0; r_p_data <= 8'd0; r_p_end <= 1'b0;
            r_ov <= 1'b0; r_obeg <= 1'b0; r_oval <= 1'b0; r_odat <= 8'd0;
            r_odone <= 1'b0; r_ook <= 1'b0; r_oerr <= cbra_pkg::ERR_NONE;
        end else begin
            r_state <= n_state; r_nest <= n_nest; r_phase <= n_phase;
            r_prefix <= n_prefix; r_hmajor <= n_hmajor; r_hbytes <= n_hbytes;
            r_hval <= n_hval; r_pleft <= n_pleft; r_mpos <= n_mpos;
            r_malive <= n_malive; r_key <= n_key; r_replied <= n_replied;
            r_argf <= n_argf; r_fin <= n_fin; r_err <= n_err; r_use <= n_use;
            r_tag <= n_tag; r_top_rem <= n_top_rem; r_top_role <= n_top_role;
            r_p_begin <= n_p_begin; r_p_valid <= n_p_valid; r_p_data <= n_p_data;
            r_p_end <= n_p_end;
            r_ov <= n_ov; r_obeg <= n_obeg; r_oval <= n_oval; r_odat <= n_odat;
            r_odone <= n_odone; r_ook <= n_ook; r_oerr <= n_oerr;
        end
    end

endmodule
